[rtl/sorted_address_range_table_defines.svh]
// ----------------------------------------------------------------------------
// Sorted address range table: assertion macros
// Clocked assertion wrappers used by the top-level table module.
// ----------------------------------------------------------------------------
`ifndef SORTED_ADDRESS_RANGE_TABLE_DEFINES_SVH
`define SORTED_ADDRESS_RANGE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SART_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SART_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sart_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted address range table package
// Sizes, operation and status codes, and the types shared by the ring and
// its controller.
// ----------------------------------------------------------------------------
package sart_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	// compare width: holds any count and any 6-bit position plus one
	localparam int CMP_W   = ((CNT_W > 6) ? CNT_W : 6) + 1;

	localparam int ADDR_W  = 32;
	localparam int ATTR_W  = 8;
	localparam int POS_W   = 6;
	localparam int KIND_W  = 3;
	localparam int STAT_W  = 2;

	localparam logic [KIND_W-1:0] K_INSERT  = 3'd0;
	localparam logic [KIND_W-1:0] K_LOOKUP  = 3'd1;
	localparam logic [KIND_W-1:0] K_EXTRACT = 3'd2;
	localparam logic [KIND_W-1:0] K_NEXT    = 3'd3;
	localparam logic [KIND_W-1:0] K_PREV    = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL        = 2'd2;
	localparam logic [STAT_W-1:0] ST_NO_NEIGHBOR = 2'd3;

	typedef struct packed {
		logic [ATTR_W-1:0] attrs;
		logic [ADDR_W-1:0] limit_addr;
		logic [ADDR_W-1:0] start_addr;
	} entry_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		entry_t            region;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		entry_t            region;
		logic [STAT_W-1:0] status;
	} res_t;

	typedef struct packed {
		logic             ready;
		logic             load;
		logic [CNT_W-1:0] count;
	} stat_t;

endpackage

[rtl/sart_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted address range table: ring cell
// Holds one table entry and takes its neighbor's entry on every shift.
// ----------------------------------------------------------------------------
module sart_cell (
	input  logic            clk,
	input  logic            shift,
	input  sart_pkg::entry_t din,
	output sart_pkg::entry_t dout
);
	import sart_pkg::*;

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= din;
		end
	end

	assign dout = entry_q;

endmodule

[rtl/sart_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted address range table: ring controller
// Rotates the cell ring once per operation, compares the head entry, and
// feeds the tail so that the ring comes back inserted, compacted or intact.
// ----------------------------------------------------------------------------
module sart_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sart_pkg::req_t   req,
	input  logic             out_free,
	input  sart_pkg::entry_t head,
	input  sart_pkg::entry_t nxt,
	output sart_pkg::entry_t feed,
	output logic             shift,
	output sart_pkg::res_t   res,
	output sart_pkg::stat_t  stat
);
	import sart_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	localparam logic [2:0] M_NONE = 3'd0;
	localparam logic [2:0] M_INS  = 3'd1;
	localparam logic [2:0] M_FIND = 3'd2;
	localparam logic [2:0] M_EXT  = 3'd3;
	localparam logic [2:0] M_PICK = 3'd4;

	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ENTRIES - 1);

	logic [1:0]       state_q;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] cnt_q;
	logic             hit_q;

	logic [2:0]       mode_q;
	logic [CMP_W-1:0] tgt_q;
	entry_t           new_q;
	entry_t           carry_q;
	res_t             res_q;

	logic [CMP_W-1:0]  k_w, cnt_w, pos_w;
	logic              valid_k, ovl, new_above, take, last;
	logic [2:0]        mode_d;
	logic [CMP_W-1:0]  tgt_d;
	logic [STAT_W-1:0] st_d;
	res_t              res_d;

	// decode of a new request against the current fill
	always_comb begin
		pos_w  = CMP_W'(req.position);
		mode_d = M_NONE;
		tgt_d  = '0;
		st_d   = ST_NOT_FOUND;
		unique case (req.kind)
			K_INSERT: begin
				if (cnt_w >= CMP_W'(ENTRIES)) begin
					st_d = ST_FULL;
				end else begin
					mode_d = M_INS;
				end
			end
			K_LOOKUP:  mode_d = M_FIND;
			K_EXTRACT: mode_d = M_EXT;
			K_NEXT: begin
				if (pos_w >= cnt_w) begin
					st_d = ST_NOT_FOUND;
				end else if (pos_w + CMP_W'(1) >= cnt_w) begin
					st_d = ST_NO_NEIGHBOR;
				end else begin
					mode_d = M_PICK;
					tgt_d  = pos_w + CMP_W'(1);
				end
			end
			K_PREV: begin
				if (pos_w >= cnt_w) begin
					st_d = ST_NOT_FOUND;
				end else if (pos_w == '0) begin
					st_d = ST_NO_NEIGHBOR;
				end else begin
					mode_d = M_PICK;
					tgt_d  = pos_w - CMP_W'(1);
				end
			end
			default: st_d = ST_NOT_FOUND;
		endcase
	end

	// head compare and tail feed
	always_comb begin
		k_w       = CMP_W'(step_q);
		cnt_w     = CMP_W'(cnt_q);
		valid_k   = k_w < cnt_w;
		ovl       = !(head.start_addr < new_q.start_addr && head.limit_addr < new_q.start_addr)
		         && !(head.start_addr > new_q.limit_addr && head.limit_addr > new_q.limit_addr);
		new_above = new_q.start_addr > head.limit_addr && new_q.limit_addr > head.limit_addr;
		last      = step_q == LAST_STEP;
		take      = 1'b0;
		feed      = head;
		unique case (mode_q)
			M_INS: begin
				if (hit_q) begin
					feed = carry_q;
				end else if ((valid_k && !new_above) || k_w == cnt_w) begin
					feed = new_q;
					take = 1'b1;
				end
			end
			M_FIND: take = !hit_q && valid_k && ovl;
			M_EXT: begin
				take = !hit_q && valid_k && ovl;
				// once the entry is dropped, pull the following one forward
				if (hit_q || take) begin
					feed = nxt;
				end
			end
			M_PICK:  take = k_w == tgt_q;
			default: take = 1'b0;
		endcase
	end

	// result word: cleared with the decoded status on a new request, filled on the hit
	always_comb begin
		res_d = res_q;
		if (state_q == S_IDLE) begin
			res_d        = '0;
			res_d.status = st_d;
		end else if (take) begin
			res_d.status   = ST_OK;
			res_d.region   = (mode_q == M_INS) ? new_q : head;
			res_d.position = k_w[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			hit_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						step_q  <= '0;
						hit_q   <= 1'b0;
					end
				end
				S_SCAN: begin
					step_q <= step_q + IDX_W'(1);
					if (take) begin
						hit_q <= 1'b1;
					end
					if (last) begin
						state_q <= S_DONE;
						if (mode_q == M_INS && (hit_q || take)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else if (mode_q == M_EXT && (hit_q || take)) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q <= mode_d;
			tgt_q  <= tgt_d;
			new_q  <= req.region;
			res_q  <= res_d;
		end else if (state_q == S_SCAN) begin
			carry_q <= head;
			res_q   <= res_d;
		end
	end

	assign shift      = state_q == S_SCAN;
	assign res        = res_q;
	assign stat.ready = state_q == S_IDLE;
	assign stat.load  = state_q == S_DONE && out_free;
	assign stat.count = cnt_q;

endmodule

[rtl/sorted_address_range_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted address range table
// Keeps up to ENTRIES address regions in ascending order in a ring of cells
// and serves insert, lookup, extract, next and prev requests.
// ----------------------------------------------------------------------------
// Every request is rotated once through the ring in the scan state and its
// result word is loaded from the done state; the next request is taken in the
// cycle after the result is loaded, so no request is taken while another is
// in the ring: the entries sit in a ring of cells that rotates once per
// request, passing one entry a cycle under the single head comparator. A
// result word may wait on the output while the next request runs. The table
// is empty after reset with no clearing pass; entries beyond the fill count
// are never reported.
`include "sorted_address_range_table_defines.svh"

module sorted_address_range_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // region_start, region_limit, region_attrs, position, pad
	input  logic [2:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // status, found_start, found_limit, found_attrs,
	                              // found_position
);
	import sart_pkg::*;

	entry_t chain [ENTRIES];
	entry_t feed;
	logic   shift;
	req_t   req;
	res_t   res;
	stat_t  stat;
	logic   start;
	logic   out_free;
	logic   fail_word;

	logic        m_tvalid_q;
	logic [79:0] m_tdata_q;

	assign req.kind              = s_tuser;
	assign req.region.start_addr = s_tdata[31:0];
	assign req.region.limit_addr = s_tdata[63:32];
	assign req.region.attrs      = s_tdata[71:64];
	assign req.position          = s_tdata[77:72];

	assign s_tready = stat.ready;
	assign start    = s_tvalid && stat.ready;
	assign out_free = !m_tvalid_q || m_tready;

	for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
		if (j == ENTRIES - 1) begin : g_tail
			sart_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.din   (feed),
				.dout  (chain[j])
			);
		end else begin : g_body
			sart_cell u_cell (
				.clk   (clk),
				.shift (shift),
				.din   (chain[j + 1]),
				.dout  (chain[j])
			);
		end
	end

	sart_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.out_free (out_free),
		.head     (chain[0]),
		.nxt      (chain[1]),
		.feed     (feed),
		.shift    (shift),
		.res      (res),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (stat.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.load) begin
			m_tdata_q <= {res.position, res.region.attrs, res.region.limit_addr,
			              res.region.start_addr, res.status};
		end
	end

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign fail_word = m_tvalid && m_tdata[1:0] != ST_OK;

	`SART_ASSERT_IMP(a_count_bound, 1'b1, stat.count <= CNT_W'(ENTRIES), "entry count overflow")
	`SART_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready during scan")
	`SART_ASSERT_IMP(a_fail_fields_zero, fail_word, m_tdata[79:2] == '0, "fields set on failure")

endmodule

[sim/sart_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted address range table checker
// Watches both stream ports, keeps a shadow copy of the region table, works
// out the result word of every accepted request and compares each result
// word that leaves the block with the oldest one still owed.
// ----------------------------------------------------------------------------
module sart_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,  // region_start, region_limit, region_attrs, position, pad
	input  logic [2:0]  s_tuser,  // kind
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,  // status, found_start, found_limit, found_attrs,
	                              // found_position
	output int          mismatches,
	output int          outstanding,
	output int          words_checked,
	output int          ok_seen,
	output int          miss_seen,
	output int          full_seen,
	output int          no_neighbor_seen
);
	import sart_pkg::*;

	entry_t shadow_tbl [ENTRIES];
	int     shadow_fill;
	res_t   owed_words [$];
	res_t   got_word;
	res_t   want_word;

	function automatic bit lies_below(entry_t a, entry_t b);
		return a.start_addr < b.start_addr && a.limit_addr < b.start_addr;
	endfunction

	function automatic bit lies_above(entry_t a, entry_t b);
		return a.start_addr > b.limit_addr && a.limit_addr > b.limit_addr;
	endfunction

	function automatic res_t report_entry(int idx);
		res_t r;
		r.status   = ST_OK;
		r.region   = shadow_tbl[idx];
		r.position = POS_W'(idx);
		return r;
	endfunction

	// updates the shadow table and returns the word the block owes
	function automatic res_t apply_request(logic [KIND_W-1:0] kind, entry_t rq,
			logic [POS_W-1:0] pos);
		res_t r;
		int   i;
		int   p;
		r        = '0;
		r.status = ST_NOT_FOUND;
		p        = pos;
		i        = 0;
		case (kind)
			K_INSERT: begin
				if (shadow_fill >= ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					// lands before the first entry it does not lie wholly above
					while (i < shadow_fill && lies_above(rq, shadow_tbl[i]))
						i++;
					for (int j = shadow_fill; j > i; j--)
						shadow_tbl[j] = shadow_tbl[j - 1];
					shadow_tbl[i] = rq;
					shadow_fill++;
					r = report_entry(i);
				end
			end
			K_LOOKUP, K_EXTRACT: begin
				while (i < shadow_fill && (lies_below(shadow_tbl[i], rq) ||
						lies_above(shadow_tbl[i], rq)))
					i++;
				if (i < shadow_fill) begin
					r = report_entry(i);
					if (kind == K_EXTRACT) begin
						for (int j = i; j + 1 < shadow_fill; j++)
							shadow_tbl[j] = shadow_tbl[j + 1];
						shadow_fill--;
					end
				end
			end
			K_NEXT: begin
				if (p < shadow_fill) begin
					if (p + 1 >= shadow_fill)
						r.status = ST_NO_NEIGHBOR;
					else
						r = report_entry(p + 1);
				end
			end
			K_PREV: begin
				if (p < shadow_fill) begin
					if (p == 0)
						r.status = ST_NO_NEIGHBOR;
					else
						r = report_entry(p - 1);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_fill = 0;
			owed_words.delete();
			mismatches       = 0;
			words_checked    = 0;
			ok_seen          = 0;
			miss_seen        = 0;
			full_seen        = 0;
			no_neighbor_seen = 0;
			outstanding     <= 0;
		end else begin
			// a result word may leave on the same edge a new request enters;
			// it always belongs to an earlier request
			if (m_tvalid && m_tready) begin
				got_word = res_t'(m_tdata);
				if (owed_words.size() == 0) begin
					$display("%0t: result word %h with nothing expected", $time, m_tdata);
					mismatches++;
				end else begin
					want_word = owed_words.pop_front();
					mismatches += check_field("status", want_word.status, got_word.status);
					mismatches += check_field("found_start", want_word.region.start_addr,
						got_word.region.start_addr);
					mismatches += check_field("found_limit", want_word.region.limit_addr,
						got_word.region.limit_addr);
					mismatches += check_field("found_attrs", want_word.region.attrs,
						got_word.region.attrs);
					mismatches += check_field("found_position", want_word.position,
						got_word.position);
					words_checked++;
				end
				case (got_word.status)
					ST_OK:          ok_seen++;
					ST_NOT_FOUND:   miss_seen++;
					ST_FULL:        full_seen++;
					ST_NO_NEIGHBOR: no_neighbor_seen++;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				owed_words.push_back(apply_request(s_tuser, s_tdata[71:0], s_tdata[77:72]));
			outstanding <= owed_words.size();
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted address range table testbench
// Drives corner-case requests, then rounds that grow, mix and drain the table
// under three pacing phases and one long output stall; the checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
	import sart_pkg::*;

	localparam int          RANDOM_ITEMS = 1880;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          LONG_HOLD    = 600;
	localparam int          ROUND_LEN    = 90;
	localparam int          KIND_LAST    = (1 << KIND_W) - 1;
	localparam logic [31:0] WINDOW_BASE  = 32'h4000_0000;

	typedef enum int {ROUND_GROW, ROUND_MIX, ROUND_DRAIN} round_e;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;  // region_start, region_limit, region_attrs, position, pad
	logic [2:0]  s_tuser  = '0;  // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;        // status, found_start, found_limit, found_attrs,
	                             // found_position

	int tx_idle_pct = 6;
	int rx_idle_pct = 85;
	bit hold_armed  = 1'b0;
	bit hold_done   = 1'b0;
	int hold_left   = 0;
	int cycle_count = 0;
	int words_sent  = 0;

	int mismatches;
	int outstanding;
	int words_checked;
	int ok_seen;
	int miss_seen;
	int full_seen;
	int no_neighbor_seen;

	always #10 clk = ~clk;

	sorted_address_range_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sart_checker table_watch (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.words_checked    (words_checked),
		.ok_seen          (ok_seen),
		.miss_seen        (miss_seen),
		.full_seen        (full_seen),
		.no_neighbor_seen (no_neighbor_seen)
	);

	// receiver pacing; one long hold-off lets the block back up into its input
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_armed && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped after %0d cycles, %0d results still owed", cycle_count,
			outstanding);
		$display("sorted_address_range_table verification failed");
		$finish;
	end

	function automatic entry_t make_region(logic [31:0] s, logic [31:0] l, logic [7:0] a);
		entry_t e;
		e.start_addr = s;
		e.limit_addr = l;
		e.attrs      = a;
		return e;
	endfunction

	// mostly small regions in one window so that overlaps are common
	function automatic entry_t random_region();
		logic [31:0] s;
		logic [31:0] l;
		case ($urandom_range(9))
			0: begin
				s = $urandom;
				l = $urandom;
			end
			1: begin
				s = $urandom_range(1) ? '1 : '0;
				l = $urandom_range(1) ? '1 : '0;
			end
			default: begin
				s = WINDOW_BASE + $urandom_range(4095);
				l = s + $urandom_range(255);
			end
		endcase
		return make_region(s, l, 8'($urandom_range(255)));
	endfunction

	function automatic entry_t random_query();
		logic [31:0] s;
		logic [31:0] l;
		case ($urandom_range(9))
			0, 1, 2: begin
				s = WINDOW_BASE + $urandom_range(4351);
				l = s;
			end
			3, 4, 5: begin
				s = WINDOW_BASE + $urandom_range(4095);
				l = s + $urandom_range(511);
			end
			6: begin
				s = $urandom;
				l = $urandom;
			end
			7: begin
				s = '0;
				l = '1;
			end
			8: begin
				// limit below start
				l = WINDOW_BASE + $urandom_range(4095);
				s = l + $urandom_range(512, 1);
			end
			default: return random_region();
		endcase
		return make_region(s, l, 8'($urandom_range(255)));
	endfunction

	function automatic logic [POS_W-1:0] random_position();
		return $urandom_range(1) ? POS_W'($urandom_range(63)) : POS_W'($urandom_range(3));
	endfunction

	// call right after a rising clk; returns once the block has taken the word
	task automatic offer_request(input logic [KIND_W-1:0] kind, input entry_t rg,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {2'b00, pos, rg};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	initial begin
		int               n;
		int               pick;
		int               cut_ins;
		int               cut_look;
		int               cut_ext;
		int               cut_next;
		int               cut_prev;
		round_e           round;
		logic [KIND_W-1:0] kind;
		entry_t           rg;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		offer_request(K_LOOKUP, make_region('0, '1, 8'h00), 6'd0);
		offer_request(K_EXTRACT, make_region('0, '1, 8'hFF), 6'd0);
		offer_request(K_NEXT, make_region('0, '0, 8'h00), 6'd0);
		offer_request(K_PREV, make_region('1, '1, 8'hFF), 6'h3F);

		// fill with extremes, an overlap and a region whose limit is below its start
		offer_request(K_INSERT, make_region(32'h0000_1000, 32'h0000_1FFF, 8'hA5), 6'd0);
		offer_request(K_INSERT, make_region('0, '0, 8'h00), 6'd0);
		offer_request(K_INSERT, make_region('1, '1, 8'hFF), 6'h3F);
		offer_request(K_INSERT, make_region(32'h0000_1800, 32'h0000_2800, 8'h5A), 6'd1);
		offer_request(K_INSERT, make_region(32'h0000_9000, 32'h0000_0100, 8'h3C), 6'd2);

		offer_request(K_LOOKUP, make_region(32'h0000_1100, 32'h0000_1100, 8'h00), 6'd0);
		offer_request(K_LOOKUP, make_region(32'h0000_5000, 32'h0000_5000, 8'h00), 6'd0);
		offer_request(K_LOOKUP, make_region(32'h0000_3000, 32'h0000_3000, 8'h00), 6'd0);

		offer_request(K_NEXT, make_region('0, '0, 8'h00), 6'd0);
		offer_request(K_NEXT, make_region('0, '0, 8'h00), 6'd4);
		offer_request(K_PREV, make_region('0, '0, 8'h00), 6'd0);
		offer_request(K_PREV, make_region('0, '0, 8'h00), 6'd2);
		offer_request(K_NEXT, make_region('0, '0, 8'h00), 6'h3F);

		offer_request(K_EXTRACT, make_region(32'h0000_1800, 32'h0000_1800, 8'h00), 6'd0);
		offer_request(K_EXTRACT, make_region('1, '1, 8'h00), 6'd0);
		offer_request(K_LOOKUP, make_region('1, '1, 8'h00), 6'd0);

		for (int k = K_PREV + 1; k <= KIND_LAST; k++)
			offer_request(KIND_W'(k), random_region(), random_position());

		// rounds that grow the table, churn it, then drain it
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				tx_idle_pct = 85;
				rx_idle_pct = 6;
			end
			if (n == 2 * RANDOM_ITEMS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_armed  = 1'b1;
			end
			round = round_e'((n / ROUND_LEN) % 3);
			case (round)
				ROUND_GROW: begin
					cut_ins = 70; cut_look = 78; cut_ext = 84; cut_next = 90; cut_prev = 96;
				end
				ROUND_MIX: begin
					cut_ins = 30; cut_look = 50; cut_ext = 68; cut_next = 80; cut_prev = 92;
				end
				default: begin
					cut_ins = 12; cut_look = 27; cut_ext = 80; cut_next = 88; cut_prev = 96;
				end
			endcase
			pick = $urandom_range(99);
			if (pick < cut_ins)
				kind = K_INSERT;
			else if (pick < cut_look)
				kind = K_LOOKUP;
			else if (pick < cut_ext)
				kind = K_EXTRACT;
			else if (pick < cut_next)
				kind = K_NEXT;
			else if (pick < cut_prev)
				kind = K_PREV;
			else
				kind = KIND_W'($urandom_range(KIND_LAST, K_PREV + 1));

			if (kind == K_EXTRACT && round == ROUND_DRAIN && $urandom_range(99) < 40)
				rg = make_region('0, '1, 8'($urandom_range(255)));  // always hits if not empty
			else if (kind == K_LOOKUP || kind == K_EXTRACT)
				rg = random_query();
			else
				rg = random_region();
			offer_request(kind, rg, random_position());
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);

		$display("%0d requests: corner cases, then grow, churn and drain rounds", words_sent);
		$display("%0d words checked: %0d ok, %0d not found, %0d full, %0d no neighbor",
			words_checked, ok_seen, miss_seen, full_seen, no_neighbor_seen);
		if (mismatches == 0)
			$display("sorted_address_range_table verification clean");
		else
			$display("sorted_address_range_table verification failed");
		$finish;
	end

endmodule
